@@ rtl/core/tse_pkg.sv @@
// Shared types and constants for the TLS server-name extractor.
// No dependencies; imported by every module of the block.
package tse_pkg;

	localparam int HEAD_BYTES  = 43;
	localparam int SNI_MIN_LEN = 5;

	localparam logic       KIND_NAME   = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_TRUNC  = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_last;
	} in_item_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] out_byte;
		logic       name_last;
		logic [1:0] status;
	} out_item_t;

	// One queue entry: an optional hostname beat, then an optional status beat.
	typedef struct packed {
		logic       has_byte;
		logic [7:0] name_byte;
		logic       name_last;
		logic       has_status;
		logic [1:0] status;
	} tse_op_t;

endpackage

@@ rtl/core/tse_chan_if.sv @@
// Valid/ready stream channel carrying one payload struct.
// Payload type is chosen at instantiation (tse_pkg types).
interface tse_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tls_sni_extractor_core.sv @@
// Top level of the streaming TLS ClientHello server-name extractor.
// Depends on tse_pkg, tse_chan_if, tse_parser, tse_queue, tse_emitter.
//
//  channel | dir | payload     | beat
//  --------+-----+-------------+-----------------------------------------------
//  hello   | in  | in_item_t   | one ClientHello byte, msg_last on final byte
//  host    | out | out_item_t  | one hostname byte, or the end-of-message status
//
// Flow: hello takes one byte per cycle while the op queue has room; the parser
//   decides each byte in that cycle and queues at most one op. The emitter sends
//   one beat per cycle while host is ready, so a byte that yields a hostname byte
//   and a status needs a host beat for each; the QUEUE_DEPTH-entry op queue absorbs that and short host stalls.
// Reset: arst_n clears parser state, queue pointers and count, and the emitter's
//   valid and byte-done flags; hello is ready in the first cycle after reset.
// Stalls: hello.ready drops only while the op queue is full.
module tls_sni_extractor_core
	import tse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	tse_chan_if.sink   hello,
	tse_chan_if.source host
);

	tse_op_t   push_op, head_op;
	logic      push, q_ready, q_valid, pop;
	in_item_t  in_data;
	out_item_t out_data;
	logic      out_valid;

	assign in_data = hello.data;

	// front: byte classification and field walking
	tse_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (hello.valid),
		.in_data  (in_data),
		.in_ready (hello.ready),
		.op_ready (q_ready),
		.op_push  (push),
		.op       (push_op)
	);

	// decoupling queue
	tse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_op    (push_op),
		.wr_ready (q_ready),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_op    (head_op)
	);

	// back: beat generation toward the consumer
	tse_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_valid),
		.op        (head_op),
		.op_pop    (pop),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (host.ready)
	);

	assign host.valid = out_valid;
	assign host.data  = out_data;

endmodule

@@ rtl/core/tse_parser.sv @@
// Front end: walks the ClientHello one byte per beat and queues result ops.
// Depends on tse_pkg.
module tse_parser
	import tse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	output logic     in_ready,
	input  logic     op_ready,
	output logic     op_push,
	output tse_op_t  op
);

	localparam logic [3:0] PH_HEAD     = 4'd0;
	localparam logic [3:0] PH_SID_LEN  = 4'd1;
	localparam logic [3:0] PH_SID_SKIP = 4'd2;
	localparam logic [3:0] PH_CS_HI    = 4'd3;
	localparam logic [3:0] PH_CS_LO    = 4'd4;
	localparam logic [3:0] PH_CS_SKIP  = 4'd5;
	localparam logic [3:0] PH_CMP_LEN  = 4'd6;
	localparam logic [3:0] PH_CMP_SKIP = 4'd7;
	localparam logic [3:0] PH_EXT_HI   = 4'd8;
	localparam logic [3:0] PH_EXT_LO   = 4'd9;
	localparam logic [3:0] PH_EXT_HDR  = 4'd10;
	localparam logic [3:0] PH_EXT_SKIP = 4'd11;
	localparam logic [3:0] PH_SNI_HDR  = 4'd12;
	localparam logic [3:0] PH_NAME     = 4'd13;
	localparam logic [3:0] PH_DONE     = 4'd14;

	logic [3:0]  phase_q, phase_d;
	logic [5:0]  head_q, head_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] ext_q, ext_d;
	logic [15:0] name_q, name_d;
	logic        found_q, found_d;
	logic        emit, emit_last;
	logic [16:0] used;
	logic [7:0]  b;
	logic        accept;
	logic [1:0]  st;

	assign b        = in_data.in_byte;
	assign in_ready = op_ready;
	assign accept   = in_valid && op_ready;

	// next phase when an extension header may start (needs 4 bytes left)
	function automatic logic [3:0] ext_gate(input logic [15:0] left);
		return (left < 16'd4) ? PH_DONE : PH_EXT_HDR;
	endfunction

	always_comb begin
		phase_d   = phase_q;
		head_d    = head_q;
		skip_d    = skip_q;
		acc_d     = acc_q;
		ext_d     = ext_q;
		name_d    = name_q;
		found_d   = found_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		used      = 17'd4 + {1'b0, acc_d};
		case (phase_q)
			PH_HEAD: begin
				head_d = head_q + 6'd1;
				if (head_d >= 6'(HEAD_BYTES)) phase_d = PH_SID_LEN;
			end
			PH_SID_LEN, PH_CMP_LEN: begin
				skip_d = {8'h00, b};
				if (phase_q == PH_SID_LEN)
					phase_d = (b == 8'h00) ? PH_CS_HI : PH_SID_SKIP;
				else
					phase_d = (b == 8'h00) ? PH_EXT_HI : PH_CMP_SKIP;
			end
			PH_SID_SKIP, PH_CS_SKIP, PH_CMP_SKIP: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == 16'd0) begin
					case (phase_q)
						PH_SID_SKIP: phase_d = PH_CS_HI;
						PH_CS_SKIP:  phase_d = PH_CMP_LEN;
						default:     phase_d = PH_EXT_HI;
					endcase
				end
			end
			PH_CS_HI, PH_EXT_HI: begin
				acc_d   = {8'h00, b};
				phase_d = (phase_q == PH_CS_HI) ? PH_CS_LO : PH_EXT_LO;
			end
			PH_CS_LO: begin
				skip_d  = {acc_q[7:0], b};
				phase_d = (skip_d == 16'd0) ? PH_CMP_LEN : PH_CS_SKIP;
			end
			PH_EXT_LO: begin
				ext_d   = {acc_q[7:0], b};
				phase_d = ext_gate(ext_d);
				head_d  = 6'd0;
			end
			PH_EXT_HDR: begin
				if (head_q == 6'd0 || head_q == 6'd2) acc_d = {8'h00, b};
				else acc_d = {acc_q[7:0], b};
				used = 17'd4 + {1'b0, acc_d};
				if (head_q == 6'd1) begin
					skip_d = acc_d;   // extension type
					head_d = 6'd2;
				end else if (head_q == 6'd3) begin
					ext_d = ({1'b0, ext_q} > used) ? (ext_q - used[15:0]) : 16'd0;
					if (skip_q == 16'd0 && acc_d >= 16'(SNI_MIN_LEN)) begin
						skip_d  = acc_d - 16'(SNI_MIN_LEN);
						head_d  = 6'd0;
						phase_d = PH_SNI_HDR;
					end else begin
						skip_d = acc_d;
						if (acc_d == 16'd0) begin
							phase_d = ext_gate(ext_d);
							head_d  = 6'd0;
						end else begin
							phase_d = PH_EXT_SKIP;
						end
					end
				end else begin
					head_d = head_q + 6'd1;
				end
			end
			PH_EXT_SKIP: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == 16'd0) begin
					phase_d = ext_gate(ext_q);
					head_d  = 6'd0;
				end
			end
			PH_SNI_HDR: begin
				if (head_q == 6'd2) acc_d = {8'h00, b};        // name type
				else if (head_q == 6'd3) name_d = {8'h00, b};
				else if (head_q == 6'd4) name_d = {name_q[7:0], b};
				if (head_q >= 6'd4) begin
					if (acc_d == 16'd0) begin
						phase_d = (name_d == 16'd0) ? PH_DONE : PH_NAME;
					end else if (skip_q == 16'd0) begin
						phase_d = ext_gate(ext_q);
						head_d  = 6'd0;
					end else begin
						phase_d = PH_EXT_SKIP;
					end
				end else begin
					head_d = head_q + 6'd1;
				end
			end
			PH_NAME: begin
				name_d    = name_q - 16'd1;
				emit      = 1'b1;
				emit_last = (name_d == 16'd0);
				if (name_d == 16'd0) begin
					found_d = 1'b1;
					phase_d = PH_DONE;
				end
			end
			default: phase_d = PH_DONE;
		endcase
	end

	always_comb begin
		if (found_d) st = ST_FOUND;
		else if (phase_d == PH_NAME) st = ST_TRUNC;
		else st = ST_ABSENT;
	end

	assign op_push       = accept && (emit || in_data.msg_last);
	assign op.has_byte   = emit;
	assign op.name_byte  = b;
	assign op.name_last  = emit_last;
	assign op.has_status = in_data.msg_last;
	assign op.status     = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			head_q  <= '0;
			skip_q  <= '0;
			acc_q   <= '0;
			ext_q   <= '0;
			name_q  <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (in_data.msg_last) begin
				phase_q <= PH_HEAD;
				head_q  <= '0;
				skip_q  <= '0;
				acc_q   <= '0;
				ext_q   <= '0;
				name_q  <= '0;
				found_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				head_q  <= head_d;
				skip_q  <= skip_d;
				acc_q   <= acc_d;
				ext_q   <= ext_d;
				name_q  <= name_d;
				found_q <= found_d;
			end
		end
	end

endmodule

@@ rtl/core/tse_queue.sv @@
// Small FIFO of result ops between the parser and the emitter.
// Depends on tse_pkg.
module tse_queue
	import tse_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  tse_op_t wr_op,
	output logic    wr_ready,
	input  logic    pop,
	output logic    rd_valid,
	output tse_op_t rd_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tse_op_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op    = mem_q[rd_ptr_q];
	assign do_push  = push && wr_ready;
	assign do_pop   = pop && rd_valid;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ rtl/core/tse_emitter.sv @@
// Back end: turns queued ops into output beats through an output register.
// Depends on tse_pkg.
module tse_emitter
	import tse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	input  tse_op_t   op,
	output logic      op_pop,
	output logic      out_valid,
	output out_item_t out_data,
	input  logic      out_ready
);

	logic      valid_q;
	out_item_t data_q;
	logic      byte_done_q;   // hostname beat of head op already sent
	logic      load;
	logic      send_byte;

	assign load      = op_valid && (!valid_q || out_ready);
	assign send_byte = op.has_byte && !byte_done_q;
	assign op_pop    = load && !(send_byte && op.has_status);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_byte) begin
				data_q.out_kind  <= KIND_NAME;
				data_q.out_byte  <= op.name_byte;
				data_q.name_last <= op.name_last;
				data_q.status    <= ST_FOUND;
			end else begin
				data_q.out_kind  <= KIND_STATUS;
				data_q.out_byte  <= 8'h00;
				data_q.name_last <= 1'b0;
				data_q.status    <= op.status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			byte_done_q <= 1'b0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load) byte_done_q <= send_byte && op.has_status;
		end
	end

endmodule
